>>> design/csvtok_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package csvtok_pkg;

    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 16;
    localparam int ROW_W   = 10;
    localparam int COLS_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CELL = 3'd4;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
    localparam logic [BYTE_W-1:0] NEWLINE_RESET   = 8'd10;

    typedef enum logic [1:0] {
        MODE_UNQUOTED,
        MODE_QUOTED,
        MODE_SEEN
    } quote_mode_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [BYTE_W-1:0] char_out;
        logic              char_valid;
        logic              cell_end;
        logic [CELL_W-1:0] cell_index;
        logic              row_end;
        logic [ROW_W-1:0]  row_index;
        logic [COLS_W-1:0] row_columns;
        logic [ROW_W-1:0]  rows_done;
    } result_t;

endpackage

>>> design/csvtok_core.sv
// Tokenizer state, configuration registers and the per-byte step logic.
module csvtok_core
    import csvtok_pkg::*;
#(
    parameter int CELL_MAX_LEN = 256,
    parameter int ROW_LIMIT    = 1024,
    parameter int COL_LIMIT    = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_write_t        cfg,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              last_byte,
    output result_t           result
);

    localparam int LEN_W = $clog2(CELL_MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(CELL_MAX_LEN - 1);
    localparam longint CELL_SPAN = longint'(ROW_LIMIT) * longint'(COL_LIMIT) - 64'sd1;
    localparam logic [CELL_W-1:0] CELL_CAP =
        (CELL_SPAN > 64'sd65535) ? 16'hFFFF : CELL_W'(CELL_SPAN);
    localparam logic [ROW_W-1:0] ROW_CAP =
        (ROW_LIMIT - 1 > 1023) ? 10'h3FF : ROW_W'(ROW_LIMIT - 1);
    localparam logic [COLS_W-1:0] COLS_MAX = '1;

    // configuration
    logic [BYTE_W-1:0] delim_reg, quote_reg, newline_reg;
    logic [ROW_W-1:0]  first_row_reg;
    logic [CELL_W-1:0] first_cell_reg;

    // stream state
    quote_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [COLS_W-1:0] fc_reg, fc_next;
    logic [CELL_W-1:0] cp_reg, cp_next;
    logic [ROW_W-1:0]  rp_reg, rp_next;

    logic is_delim, is_nl, is_quote;
    logic plain, quoted_put;

    assign is_delim = (byte_in == delim_reg);
    assign is_nl    = (byte_in == newline_reg);
    assign is_quote = (byte_in == quote_reg);

    // plain: byte handled as unquoted text (also after a closing quote)
    assign plain      = (mode_reg == MODE_UNQUOTED) || (mode_reg == MODE_SEEN && !is_quote);
    assign quoted_put = (mode_reg == MODE_QUOTED && !is_quote) ||
                        (mode_reg == MODE_SEEN && is_quote);

    // quoting mode next state
    always_comb
    begin
        case (mode_reg)
            MODE_QUOTED:
            begin
                mode_next = is_quote ? MODE_SEEN : MODE_QUOTED;
            end
            MODE_SEEN:
            begin
                if (is_quote)
                    mode_next = MODE_QUOTED;
                else if (!is_delim && !is_nl)
                    mode_next = MODE_UNQUOTED;
                else
                    mode_next = MODE_UNQUOTED;
            end
            default:
            begin
                if (!is_delim && !is_nl && is_quote)
                    mode_next = MODE_QUOTED;
                else
                    mode_next = MODE_UNQUOTED;
            end
        endcase
        if (last_byte)
            mode_next = MODE_UNQUOTED;
    end

    // results and counters
    logic              put, keep, close1, row1, flush;
    logic [LEN_W-1:0]  len1;
    logic [COLS_W-1:0] fc1, fc_sel;
    logic [CELL_W-1:0] cp1, cp2;
    logic [ROW_W-1:0]  rp_inc, rp_fin;

    always_comb
    begin
        put    = quoted_put || (plain && !is_delim && !is_nl && !is_quote);
        keep   = put && (len_reg < LEN_LIMIT);
        close1 = plain && (is_delim || is_nl);
        row1   = plain && !is_delim && is_nl;

        len1 = close1 ? '0 : len_reg + LEN_W'(keep);
        if (row1)
            fc1 = '0;
        else if (plain && is_delim && fc_reg != COLS_MAX)
            fc1 = fc_reg + 1'b1;
        else
            fc1 = fc_reg;

        cp1 = (close1 && cp_reg < CELL_CAP) ? cp_reg + 1'b1 : cp_reg;
        // end of stream closes a pending cell and its row
        flush = last_byte && (len1 != '0 || fc1 != '0);
        cp2 = (flush && cp1 < CELL_CAP) ? cp1 + 1'b1 : cp1;

        rp_inc = (rp_reg < ROW_CAP) ? rp_reg + 1'b1 : rp_reg;
        rp_fin = (row1 || flush) ? rp_inc : rp_reg;
        fc_sel = row1 ? fc_reg : fc1;

        result.char_out    = keep ? byte_in : '0;
        result.char_valid  = keep;
        result.cell_end    = close1 || flush;
        result.cell_index  = flush ? cp1 : (close1 ? cp_reg : '0);
        result.row_end     = row1 || flush;
        result.row_index   = (row1 || flush) ? rp_reg : '0;
        result.row_columns = !(row1 || flush) ? '0 :
                             (fc_sel == COLS_MAX) ? COLS_MAX : fc_sel + 1'b1;
        result.rows_done   = rp_fin - first_row_reg;

        if (last_byte)
        begin
            len_next = '0;
            fc_next  = '0;
            cp_next  = first_cell_reg;
            rp_next  = first_row_reg;
        end
        else
        begin
            len_next = len1;
            fc_next  = fc1;
            cp_next  = cp2;
            rp_next  = rp_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg      <= DELIMITER_RESET;
            quote_reg      <= QUOTE_RESET;
            newline_reg    <= NEWLINE_RESET;
            first_row_reg  <= '0;
            first_cell_reg <= '0;
            mode_reg       <= MODE_UNQUOTED;
            len_reg        <= '0;
            fc_reg         <= '0;
            cp_reg         <= '0;
            rp_reg         <= '0;
        end
        else
        begin
            if (step_en)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                fc_reg   <= fc_next;
                cp_reg   <= cp_next;
                rp_reg   <= rp_next;
            end
            if (cfg.we)
            begin
                case (cfg.index)
                    REG_DELIMITER:  delim_reg   <= cfg.data[BYTE_W-1:0];
                    REG_QUOTE:      quote_reg   <= cfg.data[BYTE_W-1:0];
                    REG_NEWLINE:    newline_reg <= cfg.data[BYTE_W-1:0];
                    REG_FIRST_ROW:
                    begin
                        first_row_reg <= cfg.data[ROW_W-1:0];
                        rp_reg        <= cfg.data[ROW_W-1:0];
                    end
                    REG_FIRST_CELL:
                    begin
                        first_cell_reg <= cfg.data[CELL_W-1:0];
                        cp_reg         <= cfg.data[CELL_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> design/csv_field_tokenizer_top.sv
// Top level of the streaming CSV field tokenizer.
// The tokenizer takes one byte of CSV text per cycle unless stalled and
// returns exactly one result per byte: the byte itself when it is kept in
// the current cell, a cell-end flag with the cell's storage index, and a
// row-end flag with the row's index and column count, plus the running
// number of rows of this stream. Each byte passes an input request register,
// then the result register. The rate is set by the update of the quoting
// mode, cell length, column count and the two index pointers, which every
// byte reads and writes. While a result waits on a stalled master side, one
// more byte is taken into the input register; s_tready then stays low until
// the waiting result is taken.
// Configuration (delimiter, quote and newline bytes, first row and first cell
// index) is written through cfg_we/cfg_index/cfg_data while the stream is
// idle; writing first_row or first_cell also reloads the matching pointer.
// The byte marked by s_tlast flushes any open cell and row and restarts the
// stream state. No clearing pass is needed after reset.
module csv_field_tokenizer_top
    import csvtok_pkg::*;
#(
    parameter int CELL_MAX_LEN = 256,
    parameter int ROW_LIMIT    = 1024,
    parameter int COL_LIMIT    = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_in
    input  logic                  s_tlast,   // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] char_out, [23:8] cell_index, [33:24] row_index,
    // [45:34] row_columns, [55:46] rows_done
    output logic [55:0]           m_tdata,
    output logic [1:0]            m_tuser,   // [0] char_valid, [1] cell_end
    output logic                  m_tlast    // row_end
);

    // input request register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    result_t           step_result;
    cfg_write_t        cfg;
    logic              advance;

    // the byte in the input register steps the tokenizer when the
    // result register is empty or being taken this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    csvtok_core #(
        .CELL_MAX_LEN (CELL_MAX_LEN),
        .ROW_LIMIT    (ROW_LIMIT),
        .COL_LIMIT    (COL_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step_en   (advance),
        .byte_in   (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.rows_done, out_reg.row_columns, out_reg.row_index,
                       out_reg.cell_index, out_reg.char_out};
    assign m_tuser  = {out_reg.cell_end, out_reg.char_valid};
    assign m_tlast  = out_reg.row_end;

endmodule

>>> design/csvtok_checker.sv
// Port-level checks on the tokenizer result stream, bound to the top level.
module csvtok_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // a completed row always completes its last cell too
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("row end without cell end");

    // dropped or absent character reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("char_out nonzero without char_valid");

    // row fields are zero unless a row ends; a row has at least one cell
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast ? (m_tdata[45:34] != 12'd0)
                              : (m_tdata[33:24] == 10'd0 && m_tdata[45:34] == 12'd0)))
        else $error("row fields inconsistent with row end");

endmodule

bind csv_field_tokenizer_top csvtok_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tb.sv
// Self-checking testbench for csv_field_tokenizer_top: directed and random CSV streams.
module tb;
    import csvtok_pkg::*;

    localparam int CELL_MAX_LEN = 256;
    localparam int ROW_LIMIT    = 1024;
    localparam int COL_LIMIT    = 64;

    // Index saturation points, derived from the size parameters.
    localparam int CELL_CAP = (ROW_LIMIT * COL_LIMIT - 1 > 65535) ? 65535
                                                                  : ROW_LIMIT * COL_LIMIT - 1;
    localparam int ROW_CAP  = (ROW_LIMIT - 1 > 1023) ? 1023 : ROW_LIMIT - 1;
    localparam int COLS_MAX = 4095;

    // An index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 14;
    localparam int REPORT_MAX   = 10;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    csv_field_tokenizer_top #(
        .CELL_MAX_LEN (CELL_MAX_LEN),
        .ROW_LIMIT    (ROW_LIMIT),
        .COL_LIMIT    (COL_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Tokenizer shadow: configuration, stream state, per-byte prediction
    // ------------------------------------------------------------------
    logic [7:0]  sep_char      = DELIMITER_RESET;
    logic [7:0]  quote_byte    = QUOTE_RESET;
    logic [7:0]  eol_char      = NEWLINE_RESET;
    logic [9:0]  row_base      = '0;
    logic [15:0] cell_base     = '0;

    quote_mode_t qmode         = MODE_UNQUOTED;
    int          kept_len      = 0;    // bytes kept in the open cell
    int          cells_in_row  = 0;    // cells ended in the open row
    int          cell_slot     = 0;    // next cell storage index
    int          row_slot      = 0;    // next row storage index

    result_t     token;                // result being built for one byte
    result_t     token_q[$];           // tokens still owed by the block

    int          bytes_sent    = 0;
    int          mismatches    = 0;
    int          checked       = 0;
    bit          calm          = 1'b0; // no idling on either side
    bit          rx_blocked    = 1'b0; // receiver held off
    event        hold_go;
    int          cycle_count   = 0;

    logic [7:0]  text_q[$];            // CSV text of the next stream

    function automatic void keep_char(logic [7:0] b);
        if (kept_len < CELL_MAX_LEN - 1)
        begin
            token.char_out   = b;
            token.char_valid = 1'b1;
            kept_len++;
        end
    endfunction

    function automatic void end_cell();
        token.cell_end   = 1'b1;
        token.cell_index = CELL_W'(cell_slot);
        if (cell_slot < CELL_CAP)
            cell_slot++;
        kept_len = 0;
    endfunction

    function automatic void end_row();
        token.row_end     = 1'b1;
        token.row_index   = ROW_W'(row_slot);
        token.row_columns = COLS_W'((cells_in_row < COLS_MAX) ? cells_in_row + 1 : COLS_MAX);
        if (row_slot < ROW_CAP)
            row_slot++;
        cells_in_row = 0;
    endfunction

    // Unquoted classification: delimiter wins over newline, newline over quote.
    function automatic void plain_text_byte(logic [7:0] b);
        if (b == sep_char)
        begin
            end_cell();
            if (cells_in_row < COLS_MAX)
                cells_in_row++;
        end
        else if (b == eol_char)
        begin
            end_cell();
            end_row();
        end
        else if (b == quote_byte)
            qmode = MODE_QUOTED;
        else
            keep_char(b);
    endfunction

    function automatic void restart_stream();
        qmode        = MODE_UNQUOTED;
        kept_len     = 0;
        cells_in_row = 0;
        cell_slot    = cell_base;
        row_slot     = row_base;
    endfunction

    function automatic result_t tokenize(logic [7:0] b, logic is_last);
        token = '0;
        case (qmode)
            MODE_QUOTED:
            begin
                if (b == quote_byte)
                    qmode = MODE_SEEN;
                else
                    keep_char(b);
            end
            MODE_SEEN:
            begin
                // doubled quote: one literal quote, stay quoted
                if (b == quote_byte)
                begin
                    keep_char(b);
                    qmode = MODE_QUOTED;
                end
                else
                begin
                    qmode = MODE_UNQUOTED;
                    plain_text_byte(b);
                end
            end
            default:
            begin
                qmode = MODE_UNQUOTED;
                plain_text_byte(b);
            end
        endcase
        // final flush of an open cell / row
        if (is_last && (kept_len != 0 || cells_in_row != 0))
        begin
            end_cell();
            end_row();
        end
        token.rows_done = ROW_W'(row_slot - row_base);
        if (is_last)
            restart_stream();
        return token;
    endfunction

    // ------------------------------------------------------------------
    // Reset, request driver and configuration writes
    // ------------------------------------------------------------------

    // Called in the step of the previous acceptance (or while idle), so
    // s_tvalid gets only one nonblocking update per step.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        token_q.push_back(tokenize(b, is_last));
        bytes_sent++;
    endtask

    // Drop valid, then wait for every owed token plus the pipeline depth.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELIMITER:  sep_char   = value[7:0];
            REG_QUOTE:      quote_byte = value[7:0];
            REG_NEWLINE:    eol_char   = value[7:0];
            REG_FIRST_ROW:
            begin
                row_base = value[9:0];
                row_slot = row_base;
            end
            REG_FIRST_CELL:
            begin
                cell_base = value;
                cell_slot = cell_base;
            end
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] sep, input logic [7:0] quo,
                             input logic [7:0] eol, input logic [9:0] row0,
                             input logic [15:0] cell0);
        write_reg(REG_DELIMITER, {8'd0, sep});
        write_reg(REG_QUOTE, {8'd0, quo});
        write_reg(REG_NEWLINE, {8'd0, eol});
        write_reg(REG_FIRST_ROW, {6'd0, row0});
        write_reg(REG_FIRST_CELL, cell0);
    endtask

    // ------------------------------------------------------------------
    // Stream text generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sep_char || b == quote_byte || b == eol_char);
        return b;
    endfunction

    // At least half of the noise bytes hit one of the three special bytes.
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0:       return sep_char;
            1:       return quote_byte;
            2:       return eol_char;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_cell();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // mostly short; now and then past the cell length cap
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 6);
            repeat (n) text_q.push_back(plain_char());
        end
        else if (kind < 9)
        begin
            text_q.push_back(quote_byte);
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 5))
                    0: text_q.push_back(sep_char);
                    1: text_q.push_back(eol_char);
                    2:
                    begin
                        text_q.push_back(quote_byte);
                        text_q.push_back(quote_byte);
                    end
                    default: text_q.push_back(plain_char());
                endcase
            end
            text_q.push_back(quote_byte);
            // text after the closing quote goes on unquoted
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(plain_char());
        end
        else
        begin
            // quote opened in the middle of a field
            text_q.push_back(plain_char());
            text_q.push_back(quote_byte);
            text_q.push_back(sep_char);
            text_q.push_back(quote_byte);
            text_q.push_back(plain_char());
        end
    endtask

    task automatic build_stream();
        int rows;
        int cols;
        text_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20)) text_q.push_back(noise_char());
            return;
        end
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            cols = $urandom_range(1, 5);
            for (int c = 0; c < cols; c++)
            begin
                add_cell();
                if (c < cols - 1)
                    text_q.push_back(sep_char);
            end
            if (r < rows - 1 || $urandom_range(0, 1) == 1)
                text_q.push_back(eol_char);
        end
        case ($urandom_range(0, 7))
            0:  repeat ($urandom_range(1, 3))
                    text_q.insert($urandom_range(0, text_q.size()), noise_char());
            1:
            begin
                // quote left open at the end of the stream
                text_q.push_back(quote_byte);
                text_q.push_back(plain_char());
            end
            default: ;
        endcase
        if (text_q.size() == 0)
            text_q.push_back(plain_char());
    endtask

    task automatic send_text(input bit end_stream);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], end_stream && i == text_q.size() - 1);
    endtask

    task automatic random_streams(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
        begin
            build_stream();
            send_text(1'b1);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default characters: quoting modes, doubled quotes, flush cases.
    task automatic test_default_chars();
        send_byte("a", 1'b0);
        send_byte(",", 1'b0);
        send_byte("\"", 1'b0);      // opens quoting
        send_byte(",", 1'b0);       // literal inside quotes
        send_byte("\"", 1'b0);      // quote seen
        send_byte("\"", 1'b0);      // doubled: literal quote
        send_byte(8'h0a, 1'b0);     // literal newline inside quotes
        send_byte("\"", 1'b0);
        send_byte("y", 1'b0);       // after closing quote: unquoted
        send_byte(8'h0a, 1'b0);     // ends cell and row
        send_byte("k", 1'b0);
        send_byte("\"", 1'b0);      // quote mid-field
        send_byte("\"", 1'b0);
        send_byte(",", 1'b0);       // closes the cell after the quote
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(",", 1'b1);       // delimiter as last byte: two cells
        send_byte("\"", 1'b0);
        send_byte("u", 1'b1);       // unterminated quote flushed
        send_byte(8'h0a, 1'b1);     // empty row then end: nothing pending
        send_byte("e", 1'b1);       // one-byte stream
        send_byte("\"", 1'b0);
        send_byte("\"", 1'b1);      // empty quoted cell at the end
        wait_idle();
    endtask

    // Extreme characters, pointer reload mid-stream, unused index, all
    // three specials equal (delimiter takes priority).
    task automatic test_custom_chars();
        write_all(8'h00, 8'hff, 8'h7f, 10'd0, 16'd0);
        send_byte("a", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte("b", 1'b0);
        wait_idle();
        write_reg(REG_FIRST_ROW, 16'd500);
        write_reg(REG_FIRST_CELL, 16'd40000);
        write_reg(REG_SPARE, 16'hffff);
        send_byte("c", 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
        write_all(",", ",", ",", 10'd0, 16'd0);
        send_byte("x", 1'b0);
        send_byte(",", 1'b0);
        send_byte(",", 1'b1);
        wait_idle();
        write_all(DELIMITER_RESET, QUOTE_RESET, NEWLINE_RESET, 10'd0, 16'd0);
    endtask

    task automatic test_random_default();
        random_streams(60);
    endtask

    // Pointers start just below and right at their saturation points.
    task automatic test_index_saturation();
        write_reg(REG_FIRST_ROW, 16'd1021);
        write_reg(REG_FIRST_CELL, 16'd65532);
        random_streams(30);
        write_reg(REG_FIRST_ROW, 16'd1023);
        write_reg(REG_FIRST_CELL, 16'hffff);
        random_streams(20);
    endtask

    task automatic test_random_configs();
        repeat (3)
        begin
            write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 65535)));
            random_streams(30);
        end
    endtask

    // Receiver holds off while the sender keeps offering bytes.
    task automatic test_rx_backpressure();
        int start;
        write_all("\t", "'", 8'h0d, 10'd7, 16'd300);
        calm  = 1'b1;
        start = bytes_sent;
        -> hold_go;
        while (bytes_sent - start < 50)
        begin
            build_stream();
            send_text(1'b1);
        end
        calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_steady_flow();
        calm = 1'b1;
        random_streams(60);
        calm = 1'b0;
    endtask

    // One row of empty cells, with the cell index running into its cap
    // on the way.
    task automatic test_wide_row();
        write_all(DELIMITER_RESET, QUOTE_RESET, NEWLINE_RESET, 10'd0, 16'd65530);
        repeat (10) send_byte(sep_char, 1'b0);
        send_byte(eol_char, 1'b1);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Long hold-off, counted here so the sender runs on regardless.
    initial
    begin
        forever
        begin
            @(hold_go);
            rx_blocked = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_blocked = 1'b0;
        end
    end

    always @(posedge clk)
        m_tready <= !rx_blocked && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);

    function automatic void report(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected %h got %h", $realtime, what, want, got);
    endfunction

    // Field layout of a token: char_out, char_valid, cell_end, cell_index,
    // row_end, row_index, row_columns, rows_done.
    always @(posedge clk)
    begin : check_tokens
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.char_out    = m_tdata[7:0];
            got.char_valid  = m_tuser[0];
            got.cell_end    = m_tuser[1];
            got.cell_index  = m_tdata[23:8];
            got.row_end     = m_tlast;
            got.row_index   = m_tdata[33:24];
            got.row_columns = m_tdata[45:34];
            got.rows_done   = m_tdata[55:46];
            if (token_q.size() == 0)
                report("token with none owed", '0, got);
            else
            begin
                want = token_q.pop_front();
                checked++;
                if (got.char_out !== want.char_out || got.char_valid !== want.char_valid
                    || got.cell_end !== want.cell_end || got.cell_index !== want.cell_index
                    || got.row_end !== want.row_end || got.row_index !== want.row_index
                    || got.row_columns !== want.row_columns
                    || got.rows_done !== want.rows_done)
                    report($sformatf("token %0d mismatch", checked), want, got);
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("csv_field_tokenizer_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        restart_stream();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_chars();
        test_custom_chars();
        test_random_default();
        test_index_saturation();
        test_random_configs();
        test_rx_backpressure();
        test_steady_flow();
        test_wide_row();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && token_q.size() == 0)
            $display("csv_field_tokenizer_top verification clean");
        else
            $display("csv_field_tokenizer_top verification failed");
        $finish;
    end

endmodule
